// ----- rtl/dsa_pkg.sv -----
`timescale 1ns / 1ps
// dsa_pkg: shared types, constants and helpers of the descriptor slot allocator
// used by dsa_ctrl, dsa_datapath and descriptor_slot_allocator_unit; no dependencies
package dsa_pkg;

    localparam int MAX_SLOTS      = 1024;
    localparam int SLOT_W         = $clog2(MAX_SLOTS);
    localparam int CNT_W          = SLOT_W + 1;
    localparam int STEP_W         = $clog2(SLOT_W + 1);

    localparam int ADDR_W         = 64;
    localparam int STRIDE_W       = 13;
    localparam int SLOT_COUNT_W   = 11;
    localparam int SLOT_INDEX_W   = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int PROD_W         = STRIDE_W + SLOT_W;
    localparam int LIM_W          = STRIDE_W + CNT_W;

    localparam logic [STRIDE_W-1:0]     STRIDE_RST     = STRIDE_W'(32);
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = SLOT_COUNT_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPU_BASE   = 3'd0,
        CFG_GPU_BASE   = 3'd1,
        CFG_STRIDE     = 3'd2,
        CFG_VISIBLE    = 3'd3,
        CFG_SLOT_COUNT = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_READ,
        S_A_MUL,
        S_A_ADD,
        S_F_SUB,
        S_F_CHK,
        S_F_DIV,
        S_F_PUSH,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic take_in;
        logic pop;
        logic mul_slot;
        logic gen_addr;
        logic sub_base;
        logic set_empty;
        logic set_range;
        logic set_full;
        logic div_start;
        logic div_step;
        logic push;
        logic load_out;
    } dsa_cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic out_range;
        logic full;
        logic div_last;
    } dsa_sts_t;

    function automatic logic [CNT_W-1:0] cap_of(input logic [SLOT_COUNT_W-1:0] sc);
        logic [CNT_W-1:0] c;
        if (sc == '0)
        begin
            c = CNT_W'(1);
        end
        else if (32'(sc) > 32'(MAX_SLOTS))
        begin
            c = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            c = CNT_W'(sc);
        end
        return c;
    endfunction

    function automatic logic [STRIDE_W-1:0] stride_of(input logic [STRIDE_W-1:0] s);
        return (s == '0) ? STRIDE_W'(1) : s;
    endfunction

endpackage

// ----- rtl/dsa_ctrl.sv -----
`timescale 1ns / 1ps
// dsa_ctrl: sequencing state machine for allocate and free items
// depends on dsa_pkg; drives dsa_datapath through dsa_cmd_t
module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dsa_sts_t sts,
    output dsa_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = (op_t'(sts.op) == OP_FREE) ? S_F_SUB : S_A_READ;
                end
            end
            S_A_READ:
            begin
                if (sts.empty)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_A_MUL;
                end
            end
            S_A_MUL:
            begin
                cmd.mul_slot = 1'b1;
                state_next   = S_A_ADD;
            end
            S_A_ADD:
            begin
                cmd.gen_addr = 1'b1;
                state_next   = S_DONE;
            end
            S_F_SUB:
            begin
                cmd.sub_base = 1'b1;
                state_next   = S_F_CHK;
            end
            S_F_CHK:
            begin
                priority if (sts.out_range)
                begin
                    cmd.set_range = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_F_DIV;
                end
            end
            S_F_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_F_PUSH;
                end
            end
            S_F_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result not presented after load");

    a_div_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_F_DIV && sts.div_last) |=> state_reg == S_F_PUSH)
        else $error("divide did not end in push");

    a_no_load_over_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.load_out)
        else $error("pending result overwritten");

endmodule

// ----- rtl/dsa_datapath.sv -----
`timescale 1ns / 1ps
// dsa_datapath: config registers, free-slot stack memory, address math and divider
// depends on dsa_pkg; controlled by dsa_ctrl through dsa_cmd_t
module dsa_datapath
    import dsa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ADDR_W-1:0]       cfg_data,
    input  logic                    operation,
    input  logic [ADDR_W-1:0]       cpu_address,
    input  dsa_cmd_t                cmd,
    output dsa_sts_t                sts,
    output logic [1:0]              status,
    output logic [SLOT_INDEX_W-1:0] slot_index,
    output logic [ADDR_W-1:0]       slot_cpu_address,
    output logic [ADDR_W-1:0]       slot_gpu_address
);

    logic [ADDR_W-1:0]       cpu_base_reg;
    logic [ADDR_W-1:0]       gpu_base_reg;
    logic [STRIDE_W-1:0]     stride_reg;
    logic                    visible_reg;
    logic [CNT_W-1:0]        cap_reg;
    logic [CNT_W-1:0]        free_count_reg;
    logic [CNT_W-1:0]        lwm_reg;
    logic [STEP_W-1:0]       step_reg;

    logic [ADDR_W-1:0]       addr_reg;
    logic [SLOT_W-1:0]       rd_data_reg;
    logic [SLOT_W-1:0]       pos_reg;
    logic                    use_mem_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [ADDR_W-1:0]       diff_reg;
    logic                    below_reg;
    logic [LIM_W-1:0]        limit_reg;
    logic [LIM_W-1:0]        rem_reg;
    logic [SLOT_W-1:0]       quo_reg;
    status_t                 res_status_reg;
    logic [SLOT_INDEX_W-1:0] res_slot_reg;
    logic [ADDR_W-1:0]       res_cpu_reg;
    logic [ADDR_W-1:0]       res_gpu_reg;
    status_t                 out_status_reg;
    logic [SLOT_INDEX_W-1:0] out_slot_reg;
    logic [ADDR_W-1:0]       out_cpu_reg;
    logic [ADDR_W-1:0]       out_gpu_reg;

    logic [SLOT_W-1:0]       mem [MAX_SLOTS];

    logic [CNT_W-1:0]        fc_dec;
    logic [SLOT_W-1:0]       pop_pos;
    logic [SLOT_W-1:0]       slot_sel;
    logic [LIM_W-1:0]        div_sh;
    logic                    div_bit;
    logic [ADDR_W-1:0]       prod_ext;

    assign fc_dec   = free_count_reg - CNT_W'(1);
    assign pop_pos  = fc_dec[SLOT_W-1:0];
    assign slot_sel = use_mem_reg ? rd_data_reg : pos_reg;
    assign div_sh   = LIM_W'(stride_reg) << step_reg;
    assign div_bit  = rem_reg >= div_sh;
    assign prod_ext = ADDR_W'(prod_reg);

    // config registers and stack bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_base_reg   <= '0;
            gpu_base_reg   <= '0;
            stride_reg     <= stride_of(STRIDE_RST);
            visible_reg    <= 1'b1;
            cap_reg        <= cap_of(SLOT_COUNT_RST);
            free_count_reg <= cap_of(SLOT_COUNT_RST);
            lwm_reg        <= cap_of(SLOT_COUNT_RST);
            step_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CPU_BASE:   cpu_base_reg <= cfg_data;
                    CFG_GPU_BASE:   gpu_base_reg <= cfg_data;
                    CFG_STRIDE:     stride_reg   <= stride_of(cfg_data[STRIDE_W-1:0]);
                    CFG_VISIBLE:    visible_reg  <= cfg_data[0];
                    CFG_SLOT_COUNT:
                    begin
                        cap_reg        <= cap_of(cfg_data[SLOT_COUNT_W-1:0]);
                        free_count_reg <= cap_of(cfg_data[SLOT_COUNT_W-1:0]);
                        lwm_reg        <= cap_of(cfg_data[SLOT_COUNT_W-1:0]);
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.pop)
            begin
                free_count_reg <= fc_dec;
                if (fc_dec < lwm_reg)
                begin
                    lwm_reg <= fc_dec;
                end
            end
            else if (cmd.push)
            begin
                free_count_reg <= free_count_reg + CNT_W'(1);
            end

            if (cmd.div_start)
            begin
                step_reg <= STEP_W'(SLOT_W - 1);
            end
            else if (cmd.div_step && step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    // stack memory: entries below the low-water mark are never read; their slot is their own position
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[free_count_reg[SLOT_W-1:0]] <= quo_reg;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= mem[pop_pos];
        end
    end

    // item payload and arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            addr_reg <= cpu_address;
        end
        if (cmd.pop)
        begin
            pos_reg     <= pop_pos;
            use_mem_reg <= free_count_reg > lwm_reg;
        end
        if (cmd.mul_slot)
        begin
            slot_reg <= slot_sel;
            prod_reg <= PROD_W'(stride_reg) * PROD_W'(slot_sel);
        end
        if (cmd.sub_base)
        begin
            diff_reg  <= addr_reg - cpu_base_reg;
            below_reg <= addr_reg < cpu_base_reg;
            limit_reg <= LIM_W'(cap_reg) * LIM_W'(stride_reg);
        end
        if (cmd.div_start)
        begin
            rem_reg <= diff_reg[LIM_W-1:0];
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_bit)
            begin
                rem_reg <= rem_reg - div_sh;
            end
            quo_reg <= SLOT_W'({quo_reg, div_bit});
        end

        priority if (cmd.gen_addr)
        begin
            res_status_reg <= ST_OK;
            res_slot_reg   <= SLOT_INDEX_W'(slot_reg);
            res_cpu_reg    <= cpu_base_reg + prod_ext;
            res_gpu_reg    <= visible_reg ? (gpu_base_reg + prod_ext) : '0;
        end
        else if (cmd.push)
        begin
            res_status_reg <= ST_OK;
            res_slot_reg   <= SLOT_INDEX_W'(quo_reg);
            res_cpu_reg    <= '0;
            res_gpu_reg    <= '0;
        end
        else if (cmd.set_empty || cmd.set_range || cmd.set_full)
        begin
            res_status_reg <= cmd.set_empty ? ST_EMPTY : (cmd.set_range ? ST_RANGE : ST_FULL);
            res_slot_reg   <= '0;
            res_cpu_reg    <= '0;
            res_gpu_reg    <= '0;
        end
        else
        begin
        end

        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_cpu_reg    <= res_cpu_reg;
            out_gpu_reg    <= res_gpu_reg;
        end
    end

    always_comb
    begin
        sts.op        = op_t'(operation);
        sts.empty     = free_count_reg == '0;
        sts.out_range = below_reg || (|diff_reg[ADDR_W-1:LIM_W])
                        || (diff_reg[LIM_W-1:0] >= limit_reg);
        sts.full      = free_count_reg >= cap_reg;
        sts.div_last  = step_reg == '0;
    end

    assign status           = out_status_reg;
    assign slot_index       = out_slot_reg;
    assign slot_cpu_address = out_cpu_reg;
    assign slot_gpu_address = out_gpu_reg;

    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= cap_reg)
        else $error("free count above capacity");

    a_lwm_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        lwm_reg <= free_count_reg)
        else $error("low-water mark above free count");

    a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (CNT_W'(quo_reg) < cap_reg))
        else $error("pushed slot outside capacity");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && !cfg_write) |=> free_count_reg == $past(fc_dec))
        else $error("pop did not decrement free count");

endmodule

// ----- rtl/descriptor_slot_allocator_unit.sv -----
`timescale 1ns / 1ps
// descriptor_slot_allocator_unit: top level of the lifo descriptor slot allocator
// allocate: read, multiply, add (stops after read if empty); free: subtract, check, divide, push
// a new item is taken only in idle; the free divider retires one quotient bit a cycle
// the result register lets the next item be accepted while a result waits
// reset: asynchronous active low; control and config registers take their reset values, free list holds all slots
module descriptor_slot_allocator_unit
    import dsa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ADDR_W-1:0]       cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    operation,
    input  logic [ADDR_W-1:0]       cpu_address,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic [SLOT_INDEX_W-1:0] slot_index,
    output logic [ADDR_W-1:0]       slot_cpu_address,
    output logic [ADDR_W-1:0]       slot_gpu_address
);

    dsa_cmd_t cmd;
    dsa_sts_t sts;

    dsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dsa_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .cpu_address      (cpu_address),
        .cmd              (cmd),
        .sts              (sts),
        .status           (status),
        .slot_index       (slot_index),
        .slot_cpu_address (slot_cpu_address),
        .slot_gpu_address (slot_gpu_address)
    );

endmodule

// ----- sim/slot_alloc_scoreboard.sv -----
`timescale 1ns / 1ps
// slot_alloc_scoreboard: watches the config port and both item channels of the slot allocator,
// keeps its own free-slot stack, predicts each result and compares it field by field
// depends on dsa_pkg for widths, status, operation and register codes
module slot_alloc_scoreboard
    import dsa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ADDR_W-1:0]       cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    operation,
    input  logic [ADDR_W-1:0]       cpu_address,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [1:0]              status,
    input  logic [SLOT_INDEX_W-1:0] slot_index,
    input  logic [ADDR_W-1:0]       slot_cpu_address,
    input  logic [ADDR_W-1:0]       slot_gpu_address,
    output int                      mismatches,
    output int                      results_owed
);

    typedef struct packed {
        status_t                 st;
        logic [SLOT_INDEX_W-1:0] slot;
        logic [ADDR_W-1:0]       cpu;
        logic [ADDR_W-1:0]       gpu;
    } slot_result_t;

    logic [ADDR_W-1:0]       heap_cpu_base;
    logic [ADDR_W-1:0]       heap_gpu_base;
    logic [STRIDE_W-1:0]     heap_stride;
    logic                    heap_visible;
    logic [SLOT_COUNT_W-1:0] heap_slot_count;
    logic [SLOT_W-1:0]       free_slots [MAX_SLOTS];
    int unsigned             free_total;
    slot_result_t            pending_slot_results [$];

    function automatic int unsigned usable_slots();
        if (heap_slot_count == '0)
        begin
            return 1;
        end
        if (int'(heap_slot_count) > MAX_SLOTS)
        begin
            return MAX_SLOTS;
        end
        return int'(heap_slot_count);
    endfunction

    function automatic void restock();
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            free_slots[i] = SLOT_W'(i);
        end
        free_total = usable_slots();
    endfunction

    function automatic void owe_result(input slot_result_t r);
        pending_slot_results = {pending_slot_results, r};
    endfunction

    function automatic slot_result_t predict_slot_op(input op_t op, input logic [ADDR_W-1:0] addr);
        slot_result_t      r;
        int unsigned       cap;
        logic [ADDR_W-1:0] step;
        logic [ADDR_W-1:0] q;
        r = '0;
        r.st = ST_OK;
        cap = usable_slots();
        step = (heap_stride == '0) ? ADDR_W'(1) : ADDR_W'(heap_stride);
        if (op == OP_ALLOC)
        begin
            if (free_total == 0)
            begin
                r.st = ST_EMPTY;
            end
            else
            begin
                free_total--;
                r.slot = free_slots[free_total];
                r.cpu = heap_cpu_base + step * ADDR_W'(r.slot);
                if (heap_visible)
                begin
                    r.gpu = heap_gpu_base + step * ADDR_W'(r.slot);
                end
            end
        end
        else if (addr < heap_cpu_base)
        begin
            r.st = ST_RANGE;
        end
        else
        begin
            q = (addr - heap_cpu_base) / step;
            if (q >= ADDR_W'(cap))
            begin
                r.st = ST_RANGE;
            end
            else if (free_total >= cap)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                r.slot = q[SLOT_W-1:0];
                free_slots[free_total] = q[SLOT_W-1:0];
                free_total++;
            end
        end
        return r;
    endfunction

    task automatic flag_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
        mismatches++;
        $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slot_result_t r;
        if (!rst_n)
        begin
            heap_cpu_base   = '0;
            heap_gpu_base   = '0;
            heap_stride     = STRIDE_RST;
            heap_visible    = 1'b1;
            heap_slot_count = SLOT_COUNT_RST;
            restock();
            pending_slot_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_slot_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t result with none expected: expected nothing, actual %h %h %h %h",
                             $time, status, slot_index, slot_cpu_address, slot_gpu_address);
                end
                else
                begin
                    r = pending_slot_results.pop_front();
                    if (status !== r.st)
                    begin
                        flag_field("status", ADDR_W'(r.st), ADDR_W'(status));
                    end
                    if (slot_index !== r.slot)
                    begin
                        flag_field("slot_index", ADDR_W'(r.slot), ADDR_W'(slot_index));
                    end
                    if (slot_cpu_address !== r.cpu)
                    begin
                        flag_field("slot_cpu_address", r.cpu, slot_cpu_address);
                    end
                    if (slot_gpu_address !== r.gpu)
                    begin
                        flag_field("slot_gpu_address", r.gpu, slot_gpu_address);
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CPU_BASE:   heap_cpu_base = cfg_data;
                    CFG_GPU_BASE:   heap_gpu_base = cfg_data;
                    CFG_STRIDE:     heap_stride = cfg_data[STRIDE_W-1:0];
                    CFG_VISIBLE:    heap_visible = cfg_data[0];
                    CFG_SLOT_COUNT:
                    begin
                        heap_slot_count = cfg_data[SLOT_COUNT_W-1:0];
                        restock();
                    end
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                owe_result(predict_slot_op(op_t'(operation), cpu_address));
            end
        end
        results_owed = pending_slot_results.size();
    end

endmodule

// ----- sim/descriptor_slot_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// descriptor_slot_allocator_unit_tb: clock, reset, register writes and allocate/free items
// for the slot allocator, with random idling on both channels; verdict from slot_alloc_scoreboard
// depends on dsa_pkg, descriptor_slot_allocator_unit and slot_alloc_scoreboard
module descriptor_slot_allocator_unit_tb;
    import dsa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 105;
    localparam int HOLD_CYCLES = 400;
    localparam int FREE_EDGE   = 88;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [ADDR_W-1:0]       cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    operation;
    logic [ADDR_W-1:0]       cpu_address;
    logic                    out_valid;
    logic                    out_ready;
    logic [1:0]              status;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [ADDR_W-1:0]       slot_cpu_address;
    logic [ADDR_W-1:0]       slot_gpu_address;
    int                      mismatches;
    int                      results_owed;

    logic                    idle_on;
    logic                    stall_request;
    logic                    stall_done;
    logic [ADDR_W-1:0]       heap_base;
    logic [ADDR_W-1:0]       heap_step;
    int unsigned             heap_cap;

    descriptor_slot_allocator_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .cpu_address      (cpu_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .slot_index       (slot_index),
        .slot_cpu_address (slot_cpu_address),
        .slot_gpu_address (slot_gpu_address)
    );

    slot_alloc_scoreboard scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .cpu_address      (cpu_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .slot_index       (slot_index),
        .slot_cpu_address (slot_cpu_address),
        .slot_gpu_address (slot_gpu_address),
        .mismatches       (mismatches),
        .results_owed     (results_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] within_slot(input int unsigned slot);
        return heap_base + heap_step * ADDR_W'(slot) + ADDR_W'($urandom_range(0, 32'(heap_step - 1)));
    endfunction

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            CFG_CPU_BASE: heap_base = val;
            CFG_STRIDE:   heap_step = (val[STRIDE_W-1:0] == '0) ? ADDR_W'(1) : ADDR_W'(val[STRIDE_W-1:0]);
            CFG_SLOT_COUNT:
            begin
                heap_cap = val[SLOT_COUNT_W-1:0];
                if (heap_cap == 0)
                begin
                    heap_cap = 1;
                end
                else if (heap_cap > MAX_SLOTS)
                begin
                    heap_cap = MAX_SLOTS;
                end
            end
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input op_t op, input logic [ADDR_W-1:0] addr);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid    = 1'b1;
        operation   = op;
        cpu_address = addr;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (results_owed != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic random_item(input int alloc_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
        begin
            send_item(OP_ALLOC, rand64());
        end
        else if (pick < FREE_EDGE)
        begin
            send_item(OP_FREE, within_slot($urandom_range(0, heap_cap - 1)));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: send_item(OP_FREE, rand64());
                1: send_item(OP_FREE, within_slot(heap_cap));
                2: send_item(OP_FREE, heap_base - ADDR_W'($urandom_range(1, 256)));
                default: send_item(OP_FREE, heap_base + heap_step * ADDR_W'(heap_cap - 1));
            endcase
        end
    endtask

    task automatic random_config();
        logic [ADDR_W-1:0] v;
        v = rand64();
        case ($urandom_range(0, 5))
            0: v[SLOT_COUNT_W-1:0] = '0;
            1: v[SLOT_COUNT_W-1:0] = SLOT_COUNT_W'(1);
            2: v[SLOT_COUNT_W-1:0] = SLOT_COUNT_W'($urandom_range(2, 16));
            3: v[SLOT_COUNT_W-1:0] = SLOT_COUNT_W'($urandom_range(17, MAX_SLOTS));
            4: v[SLOT_COUNT_W-1:0] = SLOT_COUNT_W'(MAX_SLOTS);
            default: v[SLOT_COUNT_W-1:0] = SLOT_COUNT_W'($urandom_range(MAX_SLOTS + 1, 2047));
        endcase
        // keep the free stack from the previous phase now and then
        if ($urandom_range(0, 2) != 0)
        begin
            set_reg(CFG_SLOT_COUNT, v);
        end
        v = rand64();
        case ($urandom_range(0, 5))
            0: v[STRIDE_W-1:0] = '0;
            1: v[STRIDE_W-1:0] = STRIDE_W'(1);
            2: v[STRIDE_W-1:0] = STRIDE_W'(4096);
            3: v[STRIDE_W-1:0] = STRIDE_W'(8191);
            default: v[STRIDE_W-1:0] = STRIDE_W'($urandom_range(1, 4096));
        endcase
        set_reg(CFG_STRIDE, v);
        case ($urandom_range(0, 3))
            0: set_reg(CFG_CPU_BASE, '0);
            1: set_reg(CFG_CPU_BASE, '1 - ADDR_W'($urandom_range(0, 1 << 20)));
            default: set_reg(CFG_CPU_BASE, rand64());
        endcase
        set_reg(CFG_GPU_BASE, rand64());
        set_reg(CFG_VISIBLE, rand64());
        if ($urandom_range(0, 3) == 0)
        begin
            set_reg(CFG_UNUSED, rand64());
        end
    endtask

    // receiver: random hold bursts, one long hold on request
    initial
    begin
        int n;
        out_ready  = 1'b0;
        stall_done = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (stall_request && !stall_done)
            begin
                out_ready = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                begin
                    @(negedge clk);
                end
                stall_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        int alloc_pct;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_CPU_BASE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        operation     = OP_ALLOC;
        cpu_address   = '0;
        idle_on       = 1'b1;
        stall_request = 1'b0;
        heap_base     = '0;
        heap_step     = ADDR_W'(STRIDE_RST);
        heap_cap      = MAX_SLOTS;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings, list starts full
        send_item(OP_FREE, '0);
        send_item(OP_ALLOC, '1);
        send_item(OP_FREE, ADDR_W'(32 * 1023 + 31));
        send_item(OP_FREE, ADDR_W'(32 * 1024));
        send_item(OP_FREE, '1);
        drain();

        // one slot, zero stride, base near the top, not shader visible
        set_reg(CFG_CPU_BASE, 64'hFFFF_FFFF_FFFF_F000);
        set_reg(CFG_GPU_BASE, '1);
        set_reg(CFG_STRIDE, 64'hFFFF_FFFF_FFFF_E000);
        set_reg(CFG_VISIBLE, 64'hFFFF_FFFF_FFFF_FFFE);
        set_reg(CFG_SLOT_COUNT, 64'hFFFF_FFFF_FFFF_F800);
        set_reg(CFG_UNUSED, '1);
        send_item(OP_FREE, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '1);
        send_item(OP_FREE, 64'hFFFF_FFFF_FFFF_F000);
        send_item(OP_FREE, 64'hFFFF_FFFF_FFFF_F001);
        send_item(OP_FREE, 64'hFFFF_FFFF_FFFF_F000);
        drain();

        // oversized count, largest stride, double free
        set_reg(CFG_SLOT_COUNT, 64'd2047);
        set_reg(CFG_STRIDE, 64'd8191);
        set_reg(CFG_VISIBLE, 64'd1);
        set_reg(CFG_CPU_BASE, '0);
        set_reg(CFG_GPU_BASE, 64'h8000_0000_0000_0001);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, 64'd8191 * 64'd1023);
        send_item(OP_FREE, 64'd8191 * 64'd1023);
        send_item(OP_FREE, 64'd8191 * 64'd5);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        drain();

        // wrapping addresses at the top of the space
        set_reg(CFG_SLOT_COUNT, 64'd1024);
        set_reg(CFG_STRIDE, 64'd4096);
        set_reg(CFG_CPU_BASE, '1);
        set_reg(CFG_GPU_BASE, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, '1);
        send_item(OP_FREE, '0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            random_config();
            if (ph == PHASES - 1)
            begin
                idle_on = 1'b0;
            end
            if (ph == 3)
            begin
                stall_request = 1'b1;
            end
            alloc_pct = $urandom_range(30, 58);
            repeat (PHASE_ITEMS) random_item(alloc_pct);
        end

        drain();
        repeat (40) @(negedge clk);
        if (mismatches == 0 && results_owed == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
